// ===== design/bam_pkg.sv =====
// shared widths, register codes and types for the blocked array address map
package bam_pkg;

    localparam int COORD_W  = 12;
    localparam int SIDE_W   = 13;
    localparam int BLK_W    = 7;
    localparam int IDX_W    = 25;
    localparam int QUO_W    = 13;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    localparam logic [SIDE_W-1:0] MAX_SIDE  = 13'd4096;
    localparam logic [BLK_W-1:0]  MAX_BLOCK = 7'd64;

    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ARRAY_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ARRAY_HEIGHT = 2'd2;

    typedef struct packed {
        logic [BLK_W-1:0]  block_size;
        logic [SIDE_W-1:0] array_width;
        logic [SIDE_W-1:0] array_height;
    } t_cfg;

    typedef struct packed {
        logic              out_of_range;
        logic [SIDE_W-1:0] phys_row;
        logic [SIDE_W-1:0] phys_col;
        logic [IDX_W-1:0]  blocked_index;
    } t_res;

endpackage

// ===== design/bam_regs.sv =====
// apb configuration registers: block size, array width, array height
module bam_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bam_pkg::ADDR_W-1:0]    paddr,
    input  logic [bam_pkg::DATA_W-1:0]    pwdata,
    output logic [bam_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output bam_pkg::t_cfg                 o_cfg
);

    bam_pkg::t_cfg                      r_cfg;
    logic [bam_pkg::REG_IDX_W-1:0]      w_sel;
    logic                               w_wr;

    assign pready = 1'b1;
    assign w_sel  = paddr[bam_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_size   <= bam_pkg::BLK_W'(1);
            r_cfg.array_width  <= bam_pkg::SIDE_W'(1);
            r_cfg.array_height <= bam_pkg::SIDE_W'(1);
        end else if (w_wr) begin
            unique case (w_sel)
                bam_pkg::REG_BLOCK_SIZE: begin
                    r_cfg.block_size <= pwdata[bam_pkg::BLK_W-1:0];
                end
                bam_pkg::REG_ARRAY_WIDTH: begin
                    r_cfg.array_width <= pwdata[bam_pkg::SIDE_W-1:0];
                end
                bam_pkg::REG_ARRAY_HEIGHT: begin
                    r_cfg.array_height <= pwdata[bam_pkg::SIDE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            bam_pkg::REG_BLOCK_SIZE: begin
                prdata = bam_pkg::DATA_W'(r_cfg.block_size);
            end
            bam_pkg::REG_ARRAY_WIDTH: begin
                prdata = bam_pkg::DATA_W'(r_cfg.array_width);
            end
            bam_pkg::REG_ARRAY_HEIGHT: begin
                prdata = bam_pkg::DATA_W'(r_cfg.array_height);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// ===== design/bam_div.sv =====
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
module bam_div #(
    parameter int LANES = 1,
    parameter int QUO_W = 13,
    parameter int DEN_W = 7,
    parameter int SB_W  = 1
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [LANES-1:0][DEN_W-1:0]    i_rem,
    input  logic [LANES-1:0][QUO_W-1:0]    i_num,
    input  logic [DEN_W-1:0]               i_den,
    input  logic [SB_W-1:0]                i_sb,
    output logic [LANES-1:0][QUO_W-1:0]    o_quo,
    output logic [LANES-1:0][DEN_W-1:0]    o_rem,
    output logic [DEN_W-1:0]               o_den,
    output logic [SB_W-1:0]                o_sb
);

    logic [LANES-1:0][DEN_W-1:0] r_rem [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] r_num [QUO_W];
    logic [DEN_W-1:0]            r_den [QUO_W];
    logic [SB_W-1:0]             r_sb  [QUO_W];

    logic [LANES-1:0][DEN_W-1:0] w_rem_in [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] w_num_in [QUO_W];
    logic [DEN_W-1:0]            w_den_in [QUO_W];
    logic [SB_W-1:0]             w_sb_in  [QUO_W];

    assign w_rem_in[0] = i_rem;
    assign w_num_in[0] = i_num;
    assign w_den_in[0] = i_den;
    assign w_sb_in[0]  = i_sb;

    for (genvar k = 1; k < QUO_W; k++) begin : g_link
        assign w_rem_in[k] = r_rem[k-1];
        assign w_num_in[k] = r_num[k-1];
        assign w_den_in[k] = r_den[k-1];
        assign w_sb_in[k]  = r_sb[k-1];
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][QUO_W-1:0] n_num;

        always_comb begin
            logic [DEN_W:0] v_trial;
            logic [DEN_W:0] v_diff;
            logic           v_bit;
            for (int l = 0; l < LANES; l++) begin
                // bring down the next dividend bit, quotient bit shifts in at the bottom
                v_trial  = {w_rem_in[k][l], w_num_in[k][l][QUO_W-1]};
                v_diff   = v_trial - {1'b0, w_den_in[k]};
                v_bit    = (v_trial >= {1'b0, w_den_in[k]});
                n_rem[l] = v_bit ? v_diff[DEN_W-1:0] : v_trial[DEN_W-1:0];
                n_num[l] = {w_num_in[k][l][QUO_W-2:0], v_bit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_num[k] <= n_num;
                r_den[k] <= w_den_in[k];
                r_sb[k]  <= w_sb_in[k];
            end
        end
    end

    assign o_quo = r_num[QUO_W-1];
    assign o_rem = r_rem[QUO_W-1];
    assign o_den = r_den[QUO_W-1];
    assign o_sb  = r_sb[QUO_W-1];

endmodule

// ===== design/bam_obuf.sv =====
// two-entry output buffer that decouples the pipeline from the result stream
module bam_obuf #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid & i_ready;
    assign o_ready = (r_cnt != 2'd2) | i_ready;
    assign w_push  = i_valid & o_ready;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count overflow");

    a_ptr_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr == r_rd))
        else $error("output buffer pointers disagree with count");

    a_ptr_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wr != r_rd))
        else $error("output buffer pointers disagree with count");

endmodule

// ===== design/blocked_array_address_map_unit.sv =====
// top level: blocked 2d array address map with apb configuration
//
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  tdata = column, row
//  m_*       out   m_tvalid/m_tready  tdata = blocked_index, phys_col, phys_row; tuser = out_of_range
//  apb       in    psel/penable       block_size @0x0, array_width @0x4, array_height @0x8
//
// one item per cycle while the output buffer accepts results (s_tready high)
// most of the stages are the two pipelined dividers, one quotient bit per stage (13 stages each)
// reset clears stage valid bits and the output buffer, and sets all three configuration registers to 1
// with m_tready low the two-entry output buffer fills, then the whole pipeline holds
module blocked_array_address_map_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bam_pkg::IN_TDATA_W-1:0]      s_tdata,   // column[11:0], row[23:12]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bam_pkg::OUT_TDATA_W-1:0]     m_tdata,   // blocked_index[24:0], phys_col[37:25],
                                                           // phys_row[50:38], zero[55:51]
    output logic                                m_tuser,   // out_of_range[0]
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bam_pkg::ADDR_W-1:0]          paddr,
    input  logic [bam_pkg::DATA_W-1:0]          pwdata,
    output logic [bam_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int COORD_W = bam_pkg::COORD_W;
    localparam int SIDE_W  = bam_pkg::SIDE_W;
    localparam int BLK_W   = bam_pkg::BLK_W;
    localparam int IDX_W   = bam_pkg::IDX_W;
    localparam int QUO_W   = bam_pkg::QUO_W;
    localparam int ARITH_STAGES = 3;
    localparam int NS = 1 + QUO_W + ARITH_STAGES + QUO_W;

    bam_pkg::t_cfg      w_cfg;
    logic               w_en;
    logic [NS-1:0]      r_valid;

    bam_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input stage: clamp configuration, range check, padded-width numerator
    logic [COORD_W-1:0] w_col;
    logic [COORD_W-1:0] w_row;
    logic [BLK_W-1:0]   w_b;
    logic [SIDE_W-1:0]  w_w;
    logic [SIDE_W-1:0]  w_h;
    logic [SIDE_W-1:0]  w_wpad;
    logic [SIDE_W-1:0]  w_wb;
    logic               w_oor;

    always_comb begin
        w_col = s_tdata[COORD_W-1:0];
        w_row = s_tdata[2*COORD_W-1:COORD_W];
        if (w_cfg.block_size == '0) begin
            w_b = BLK_W'(1);
        end else if (w_cfg.block_size > bam_pkg::MAX_BLOCK) begin
            w_b = bam_pkg::MAX_BLOCK;
        end else begin
            w_b = w_cfg.block_size;
        end
        w_w = (w_cfg.array_width > bam_pkg::MAX_SIDE) ? bam_pkg::MAX_SIDE
                                                      : w_cfg.array_width;
        w_h = (w_cfg.array_height > bam_pkg::MAX_SIDE) ? bam_pkg::MAX_SIDE
                                                       : w_cfg.array_height;
        w_oor  = ({1'b0, w_col} >= w_w) || ({1'b0, w_row} >= w_h);
        // zero width only happens out of range; keep the divisor nonzero anyway
        w_wpad = (w_w == '0) ? SIDE_W'(1) : w_w;
        w_wb   = w_wpad + SIDE_W'(w_b) - SIDE_W'(1);
    end

    logic [COORD_W-1:0] r0_col;
    logic [COORD_W-1:0] r0_row;
    logic               r0_oor;
    logic [BLK_W-1:0]   r0_b;
    logic [SIDE_W-1:0]  r0_wb;

    // out-of-range items run as (0, 0), which maps to all-zero results
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_col <= w_oor ? '0 : w_col;
            r0_row <= w_oor ? '0 : w_row;
            r0_oor <= w_oor;
            r0_b   <= w_b;
            r0_wb  <= w_wb;
        end
    end

    // lanes: column / b, row / b, blocks per padded row
    logic [2:0][QUO_W-1:0] w_d1_num;
    logic [2:0][QUO_W-1:0] w_d1_quo;
    logic [2:0][BLK_W-1:0] w_d1_rem;
    logic [BLK_W-1:0]      w_d1_b;
    logic                  w_d1_oor;

    assign w_d1_num = {r0_wb, {1'b0, r0_row}, {1'b0, r0_col}};

    bam_div #(
        .LANES (3),
        .QUO_W (QUO_W),
        .DEN_W (BLK_W),
        .SB_W  (1)
    ) u_div_blk (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem ('0),
        .i_num (w_d1_num),
        .i_den (r0_b),
        .i_sb  (r0_oor),
        .o_quo (w_d1_quo),
        .o_rem (w_d1_rem),
        .o_den (w_d1_b),
        .o_sb  (w_d1_oor)
    );

    // products: block-row times blocks per row, padded width, offset, block area
    logic [2*QUO_W-1:0]       w_m1;
    logic [QUO_W+BLK_W-1:0]   w_pad_prod;
    logic [2*BLK_W:0]         w_off;
    logic [2*BLK_W-1:0]       w_bb;

    assign w_m1       = w_d1_quo[1] * w_d1_quo[2];
    assign w_pad_prod = w_d1_quo[2] * w_d1_b;
    assign w_off      = w_d1_rem[1] * w_d1_b + (2*BLK_W+1)'(w_d1_rem[0]);
    assign w_bb       = w_d1_b * w_d1_b;

    logic [IDX_W-1:0]  r1_m1;
    logic [QUO_W-1:0]  r1_qc;
    logic [SIDE_W-1:0] r1_padded;
    logic [SIDE_W-1:0] r1_off;
    logic [SIDE_W-1:0] r1_bb;
    logic              r1_oor;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_m1     <= w_m1[IDX_W-1:0];
            r1_qc     <= w_d1_quo[0];
            r1_padded <= w_pad_prod[SIDE_W-1:0];
            r1_off    <= w_off[SIDE_W-1:0];
            r1_bb     <= w_bb[SIDE_W-1:0];
            r1_oor    <= w_d1_oor;
        end
    end

    logic [IDX_W-1:0]  r2_bnum;
    logic [SIDE_W-1:0] r2_padded;
    logic [SIDE_W-1:0] r2_off;
    logic [SIDE_W-1:0] r2_bb;
    logic              r2_oor;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_bnum   <= r1_m1 + IDX_W'(r1_qc);
            r2_padded <= r1_padded;
            r2_off    <= r1_off;
            r2_bb     <= r1_bb;
            r2_oor    <= r1_oor;
        end
    end

    logic [IDX_W+SIDE_W-1:0] w_idx_full;

    assign w_idx_full = r2_bnum * r2_bb + (IDX_W+SIDE_W)'(r2_off);

    logic [IDX_W-1:0]  r3_idx;
    logic [SIDE_W-1:0] r3_padded;
    logic              r3_oor;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_idx    <= w_idx_full[IDX_W-1:0];
            r3_padded <= r2_padded;
            r3_oor    <= r2_oor;
        end
    end

    // index / padded width; the quotient is a physical row, so it fits in QUO_W bits
    logic [0:0][SIDE_W-1:0] w_d2_rem_in;
    logic [0:0][QUO_W-1:0]  w_d2_num;
    logic [0:0][QUO_W-1:0]  w_d2_quo;
    logic [0:0][SIDE_W-1:0] w_d2_rem;
    logic [IDX_W:0]         w_d2_sb;

    assign w_d2_rem_in = SIDE_W'(r3_idx[IDX_W-1:QUO_W]);
    assign w_d2_num    = r3_idx[QUO_W-1:0];

    bam_div #(
        .LANES (1),
        .QUO_W (QUO_W),
        .DEN_W (SIDE_W),
        .SB_W  (IDX_W + 1)
    ) u_div_pad (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_d2_rem_in),
        .i_num (w_d2_num),
        .i_den (r3_padded),
        .i_sb  ({r3_idx, r3_oor}),
        .o_quo (w_d2_quo),
        .o_rem (w_d2_rem),
        .o_den (),
        .o_sb  (w_d2_sb)
    );

    bam_pkg::t_res w_res;
    bam_pkg::t_res w_out;

    always_comb begin
        w_res.out_of_range  = w_d2_sb[0];
        w_res.phys_row      = w_d2_quo[0];
        w_res.phys_col      = w_d2_rem[0];
        w_res.blocked_index = w_d2_sb[IDX_W:1];
    end

    // stage valid bits move with the data under one shared advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NS-2:0], s_tvalid};
        end
    end

    bam_obuf #(
        .WIDTH ($bits(bam_pkg::t_res))
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid[NS-1]),
        .i_data  (w_res),
        .o_ready (w_en),
        .o_valid (m_tvalid),
        .o_data  (w_out),
        .i_ready (m_tready)
    );

    assign s_tready = w_en;
    assign m_tdata  = {{(bam_pkg::OUT_TDATA_W - IDX_W - 2*SIDE_W){1'b0}},
                       w_out.phys_row, w_out.phys_col, w_out.blocked_index};
    assign m_tuser  = w_out.out_of_range;

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> r_valid[0])
        else $error("accepted item did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_valid))
        else $error("pipeline moved while stalled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NS-1] && w_en) |=> m_tvalid)
        else $error("finished item not in output buffer");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("out of range item with nonzero address");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the blocked array address map: scoreboard, stream drivers and apb setup
`timescale 1ns / 100ps

module testbench;

    localparam int PIPE_LATENCY  = 30;
    localparam int IDLE_LIMIT    = 3000;
    localparam int ITEMS_PER_CFG = 50;
    localparam int RANDOM_CFGS   = 8;

    // keeps the register copy, predicts the placement of each request and checks results
    class blocked_map_scoreboard;
        bit [bam_pkg::BLK_W-1:0]  blk_reg;
        bit [bam_pkg::SIDE_W-1:0] width_reg;
        bit [bam_pkg::SIDE_W-1:0] height_reg;
        bam_pkg::t_res            expected_places[$];
        int                       errors;

        function new();
            blk_reg    = 1;
            width_reg  = 1;
            height_reg = 1;
            errors     = 0;
        endfunction

        function void set_reg(logic [bam_pkg::REG_IDX_W-1:0] idx,
                              bit [bam_pkg::DATA_W-1:0] val);
            case (idx)
                bam_pkg::REG_BLOCK_SIZE:   blk_reg    = val[bam_pkg::BLK_W-1:0];
                bam_pkg::REG_ARRAY_WIDTH:  width_reg  = val[bam_pkg::SIDE_W-1:0];
                bam_pkg::REG_ARRAY_HEIGHT: height_reg = val[bam_pkg::SIDE_W-1:0];
                default: ;
            endcase
        endfunction

        function bam_pkg::t_res map_coord(bit [bam_pkg::COORD_W-1:0] col,
                                          bit [bam_pkg::COORD_W-1:0] row);
            int unsigned b, w, h, padded, per_row, blk_num, offset, idx;
            bam_pkg::t_res r;
            b = blk_reg;
            if (b == 0) b = 1;
            if (b > int'(bam_pkg::MAX_BLOCK)) b = int'(bam_pkg::MAX_BLOCK);
            w = (width_reg > bam_pkg::MAX_SIDE) ? int'(bam_pkg::MAX_SIDE) : int'(width_reg);
            h = (height_reg > bam_pkg::MAX_SIDE) ? int'(bam_pkg::MAX_SIDE) : int'(height_reg);
            r = '0;
            if (col >= w || row >= h) begin
                r.out_of_range = 1'b1;
                return r;
            end
            padded  = ((w + b - 1) / b) * b;
            per_row = padded / b;
            blk_num = (row / b) * per_row + col / b;
            offset  = (row % b) * b + col % b;
            idx     = blk_num * b * b + offset;
            r.blocked_index = idx[bam_pkg::IDX_W-1:0];
            r.phys_col      = bam_pkg::SIDE_W'(idx % padded);
            r.phys_row      = bam_pkg::SIDE_W'(idx / padded);
            return r;
        endfunction

        function void note_request(bit [bam_pkg::COORD_W-1:0] col,
                                   bit [bam_pkg::COORD_W-1:0] row);
            expected_places.push_back(map_coord(col, row));
        endfunction

        function void check_placement(bam_pkg::t_res got);
            bam_pkg::t_res exp_r;
            if (expected_places.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: idx %0d col %0d row %0d oor %0b",
                             got.blocked_index, got.phys_col, got.phys_row, got.out_of_range);
                return;
            end
            exp_r = expected_places.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected idx %0d col %0d row %0d oor %0b,",
                             exp_r.blocked_index, exp_r.phys_col, exp_r.phys_row,
                             exp_r.out_of_range,
                             " got idx %0d col %0d row %0d oor %0b",
                             got.blocked_index, got.phys_col, got.phys_row,
                             got.out_of_range);
            end
        endfunction

        function int pending();
            return expected_places.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bam_pkg::IN_TDATA_W-1:0]  s_tdata;    // column[11:0], row[23:12]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bam_pkg::OUT_TDATA_W-1:0] m_tdata;    // blocked_index[24:0], phys_col[37:25],
                                                 // phys_row[50:38]
    logic                            m_tuser;    // out_of_range[0]
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bam_pkg::ADDR_W-1:0]      paddr;
    logic [bam_pkg::DATA_W-1:0]      pwdata;
    logic [bam_pkg::DATA_W-1:0]      prdata;
    logic                            pready;

    blocked_map_scoreboard sb;
    bit idle_en;
    bit stall_en;
    int idle_cycles = 0;

    blocked_array_address_map_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_coord(bit [bam_pkg::COORD_W-1:0] col, bit [bam_pkg::COORD_W-1:0] row);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_request(col, row);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [bam_pkg::REG_IDX_W-1:0] idx, bit [bam_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(int blk, int width, int height);
        wait_drained();
        apb_write(bam_pkg::REG_BLOCK_SIZE, blk);
        apb_write(bam_pkg::REG_ARRAY_WIDTH, width);
        apb_write(bam_pkg::REG_ARRAY_HEIGHT, height);
    endtask

    // mostly in-range coordinates so the address math gets exercised
    task automatic send_random_coord();
        int w, h;
        w = (sb.width_reg > bam_pkg::MAX_SIDE) ? int'(bam_pkg::MAX_SIDE) : int'(sb.width_reg);
        h = (sb.height_reg > bam_pkg::MAX_SIDE) ? int'(bam_pkg::MAX_SIDE) : int'(sb.height_reg);
        if ($urandom_range(0, 99) < 80 && w > 0 && h > 0)
            send_coord(bam_pkg::COORD_W'($urandom_range(0, w - 1)),
                       bam_pkg::COORD_W'($urandom_range(0, h - 1)));
        else
            send_coord(bam_pkg::COORD_W'($urandom), bam_pkg::COORD_W'($urandom));
    endtask

    // receiver back-pressure
    initial begin
        int gap;
        m_tready = 1'b1;
        forever begin
            gap = stall_en ? pick_gap() : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        bam_pkg::t_res got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.blocked_index = m_tdata[24:0];
            got.phys_col      = m_tdata[37:25];
            got.phys_row      = m_tdata[50:38];
            got.out_of_range  = m_tuser;
            sb.check_placement(got);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int blk, width, height;
        sb          = new();
        idle_en     = 1'b1;
        stall_en    = 1'b1;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: a 1x1 array
        send_coord(0, 0);
        send_coord(1, 0);
        send_coord(0, 1);
        // zero block size and zero dimensions: everything out of range
        set_geometry(0, 0, 0);
        send_coord(0, 0);
        send_coord(12'hfff, 12'hfff);
        // saturation of all three registers
        set_geometry(127, 8191, 8191);
        send_coord(0, 0);
        send_coord(12'hfff, 12'hfff);
        send_coord(12'hfff, 0);
        send_coord(0, 12'hfff);
        send_coord(2047, 2048);
        send_coord(63, 64);
        set_geometry(64, 4096, 4096);
        send_coord(12'hfff, 12'hfff);
        send_coord(64, 63);
        // unit blocks give plain row-major order
        set_geometry(1, 4096, 4096);
        send_coord(12'hfff, 12'hfff);
        send_coord(1234, 2345);
        // one column padded out to a full block
        set_geometry(5, 1, 4096);
        send_coord(0, 4095);
        send_coord(1, 0);
        set_geometry(7, 100, 37);
        send_coord(99, 36);
        send_coord(100, 0);
        send_coord(0, 37);

        for (int p = 0; p < RANDOM_CFGS; p++) begin
            case ($urandom_range(0, 9))
                0:       blk = $urandom_range(65, 127);
                1:       blk = 0;
                default: blk = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 3))
                0:       width = $urandom_range(1, 64);
                1:       width = $urandom_range(65, 600);
                2:       width = $urandom_range(601, 4096);
                default: width = $urandom_range(1, 8191);
            endcase
            case ($urandom_range(0, 3))
                0:       height = $urandom_range(1, 64);
                1:       height = $urandom_range(65, 600);
                2:       height = $urandom_range(601, 4096);
                default: height = $urandom_range(1, 8191);
            endcase
            set_geometry(blk, width, height);
            idle_en  = (p % 3) != 0;
            stall_en = (p % 4) != 1;
            repeat (ITEMS_PER_CFG) send_random_coord();
        end

        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/bam_pkg.sv
design/bam_regs.sv
design/bam_div.sv
design/bam_obuf.sv
design/blocked_array_address_map_unit.sv
tb/sv/testbench.sv
